>>> rtl/ima_pkg.sv
`default_nettype none

package ima_pkg;

	// Field and register widths
	localparam int BYTE_W     = 8;
	localparam int SAMPLE_W   = 16;
	localparam int BLOCK_W    = 13;
	localparam int CHCNT_W    = 2;
	localparam int REG_IDX_W  = 1;
	localparam int REG_DATA_W = 13;
	localparam int INDEX_W    = 7;
	localparam int STEP_W     = 15;

	localparam int MAX_BLOCK_BYTES_DEF = 4096;
	localparam int BLOCK_MAX           = (2 ** BLOCK_W) - 1;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_BYTES   = 1'b1;

	localparam logic [CHCNT_W-1:0] CHCNT_RESET = 2'd1;
	localparam logic [BLOCK_W-1:0] BLOCK_RESET = 13'd1024;

	// Header layout: four bytes per channel
	localparam logic [BLOCK_W-1:0] HDR_MONO   = 13'd4;
	localparam logic [BLOCK_W-1:0] HDR_STEREO = 13'd8;

	localparam logic [1:0] PART_SAMPLE_LO = 2'd0;
	localparam logic [1:0] PART_SAMPLE_HI = 2'd1;
	localparam logic [1:0] PART_INDEX_LO  = 2'd2;
	localparam logic [1:0] PART_INDEX_HI  = 2'd3;

	localparam logic [INDEX_W-1:0] INDEX_MAX = 7'd88;
	localparam logic [BYTE_W-1:0]  INDEX_MAX_BYTE = 8'd88;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

	// Work held in the input stage
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_INDEX  = 2'd1,
		OP_DATA   = 2'd2
	} op_t;

	localparam logic [STEP_W-1:0] QUANT_STEP [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
		15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
		15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
		15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
		15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
		15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
		15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
		15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
		15'd29794, 15'd32767
	};

	// Step index adjustment per nibble magnitude
	function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
		logic signed [4:0] adj;
		case (mag)
			3'd4:    adj = 5'sd2;
			3'd5:    adj = 5'sd4;
			3'd6:    adj = 5'sd6;
			3'd7:    adj = 5'sd8;
			default: adj = -5'sd1;
		endcase
		return adj;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ima_in_if.sv
`default_nettype none

interface ima_in_if import ima_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              first_of_block;

	modport source (output valid, output data_byte, output first_of_block, input ready);
	modport sink   (input valid, input data_byte, input first_of_block, output ready);
endinterface

`default_nettype wire

>>> rtl/ima_out_if.sv
`default_nettype none

interface ima_out_if import ima_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       channel;
	logic                       last;

	modport source (output valid, output sample, output channel, output last, input ready);
	modport sink   (input valid, input sample, input channel, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/ima_adpcm_block_decoder.sv
// IMA ADPCM block decoder.
// adpcm: raw block bytes, one item per byte; first_of_block restarts header parsing.
// pcm: decoded samples with their channel; last marks the second sample of a data
//   byte and every header sample.
// wr_en/wr_index/wr_data: register 0 is channel_count, register 1 is block_bytes;
//   write only while the block is idle.
// A sample is registered in the input stage and then in the output register before
//   it is valid on pcm; the second sample of a data byte follows the first.
// Throughput: the single nibble decode unit takes one nibble per cycle while pcm
//   does not stall, so a data byte holds the input stage for both of its nibbles;
//   header low bytes and bytes past the block end never enter the input stage.
// The input stage takes a new byte while a result waits in the output register;
//   when pcm stalls the output register holds and adpcm drops ready once the
//   input stage is full.
// Reset: mono, 1024-byte blocks, position, predictors and step indexes zero, so
//   the first byte after reset starts a block.
`default_nettype none

module ima_adpcm_block_decoder import ima_pkg::*; #(
	parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [REG_IDX_W-1:0]  wr_index,
	input  wire logic [REG_DATA_W-1:0] wr_data,
	ima_in_if.sink                     adpcm,
	ima_out_if.source                  pcm
);

	localparam logic [BLOCK_W-1:0] LIMIT_CAP =
		BLOCK_W'((MAX_BLOCK_BYTES > BLOCK_MAX) ? BLOCK_MAX : MAX_BLOCK_BYTES);

	// Configuration registers
	logic [CHCNT_W-1:0] channel_count_q;
	logic [BLOCK_W-1:0] block_bytes_q;

	// Byte parser state
	logic [BLOCK_W-1:0] byte_position_q;
	logic [BYTE_W-1:0]  header_low_byte_q;

	// Channel state
	logic signed [SAMPLE_W-1:0] predictor_q [2];
	logic [INDEX_W-1:0]         step_index_q [2];
	logic [1:0]                 index_invalid_q;

	// Input stage: word holds the header sample, {bad, index} or the data byte
	logic                valid_s1;
	op_t                 op_s1;
	logic                ch_s1;
	logic                phase_s1;
	logic [SAMPLE_W-1:0] word_s1;

	// Output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       channel_q;
	logic                       last_q;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHCNT_RESET;
			block_bytes_q   <= BLOCK_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CHANNEL_COUNT: channel_count_q <= wr_data[CHCNT_W-1:0];
				REG_BLOCK_BYTES:   block_bytes_q   <= wr_data[BLOCK_W-1:0];
				default:           ;
			endcase
		end
	end

	// Byte classification
	logic               stereo;
	logic [BLOCK_W-1:0] limit;
	logic [BLOCK_W-1:0] pos;
	logic               in_block;
	logic               in_header;
	logic [1:0]         part;
	logic               pos_ch;
	logic               takes_stage;
	op_t                new_op;
	logic [SAMPLE_W-1:0] new_word;
	logic               in_fire;
	logic               s1_go;
	logic               s1_done;

	always_comb begin
		stereo    = channel_count_q[1];
		limit     = (block_bytes_q > LIMIT_CAP) ? LIMIT_CAP : block_bytes_q;
		pos       = adpcm.first_of_block ? '0 : byte_position_q;
		in_block  = pos < limit;
		in_header = pos < (stereo ? HDR_STEREO : HDR_MONO);
		part      = pos[1:0];
		pos_ch    = stereo & pos[2];
		takes_stage = 1'b0;
		new_op      = OP_DATA;
		new_word    = {{(SAMPLE_W-BYTE_W){1'b0}}, adpcm.data_byte};
		if (in_block) begin
			if (in_header) begin
				case (part)
					PART_SAMPLE_HI: begin
						takes_stage = 1'b1;
						new_op      = OP_SAMPLE;
						new_word    = {adpcm.data_byte, header_low_byte_q};
					end
					PART_INDEX_HI: begin
						takes_stage = 1'b1;
						new_op      = OP_INDEX;
						new_word    = {7'd0,
							(adpcm.data_byte != '0) || (header_low_byte_q > INDEX_MAX_BYTE),
							header_low_byte_q};
					end
					default: takes_stage = 1'b0;
				endcase
			end else begin
				takes_stage = 1'b1;
			end
		end
	end

	assign in_fire     = adpcm.valid && adpcm.ready;
	assign adpcm.ready = !valid_s1 || s1_done;

	// Position and header low byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q   <= '0;
			header_low_byte_q <= '0;
		end else if (in_fire) begin
			byte_position_q <= in_block ? pos + 13'd1 : pos;
			if (in_block && in_header &&
					(part == PART_SAMPLE_LO || part == PART_INDEX_LO)) begin
				header_low_byte_q <= adpcm.data_byte;
			end
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (in_fire && takes_stage) begin
			valid_s1 <= 1'b1;
			phase_s1 <= 1'b0;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (s1_go) begin
			phase_s1 <= 1'b1;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_fire && takes_stage) begin
			op_s1   <= new_op;
			ch_s1   <= pos_ch;
			word_s1 <= new_word;
		end
	end

	// Nibble decode
	logic [3:0]                 nibble;
	logic [INDEX_W-1:0]         idx;
	logic [STEP_W-1:0]          step;
	logic [16:0]                delta;
	logic signed [17:0]         lin;
	logic signed [SAMPLE_W-1:0] lin_sat;
	logic signed [7:0]          idx_next;
	logic [INDEX_W-1:0]         idx_clamped;

	always_comb begin
		nibble = phase_s1 ? word_s1[7:4] : word_s1[3:0];
		idx    = step_index_q[ch_s1];
		step   = (idx > INDEX_MAX) ? QUANT_STEP[INDEX_MAX] : QUANT_STEP[idx];
		delta  = 17'(step >> 3);
		if (nibble[0]) delta = delta + 17'(step >> 2);
		if (nibble[1]) delta = delta + 17'(step >> 1);
		if (nibble[2]) delta = delta + 17'(step);
		lin = nibble[3] ? (18'(predictor_q[ch_s1]) - $signed({1'b0, delta}))
		                : (18'(predictor_q[ch_s1]) + $signed({1'b0, delta}));
		if (lin > 18'(SAMPLE_MAX))      lin_sat = SAMPLE_MAX;
		else if (lin < 18'(SAMPLE_MIN)) lin_sat = SAMPLE_MIN;
		else                            lin_sat = lin[SAMPLE_W-1:0];
		idx_next = $signed({1'b0, idx}) + 8'(index_adjust(nibble[2:0]));
		if (idx_next < 8'sd0)                         idx_clamped = '0;
		else if (idx_next > $signed({1'b0, INDEX_MAX})) idx_clamped = INDEX_MAX;
		else                                          idx_clamped = idx_next[INDEX_W-1:0];
	end

	// Stage advance: index writes need no output slot
	assign s1_go   = valid_s1 && (op_s1 == OP_INDEX || !out_valid_q || pcm.ready);
	assign s1_done = s1_go && (op_s1 != OP_DATA || phase_s1);

	// Channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predictor_q[0]  <= '0;
			predictor_q[1]  <= '0;
			step_index_q[0] <= '0;
			step_index_q[1] <= '0;
			index_invalid_q <= '0;
		end else if (s1_go) begin
			case (op_s1)
				OP_SAMPLE: predictor_q[ch_s1] <= $signed(word_s1);
				OP_INDEX: begin
					index_invalid_q[ch_s1] <= word_s1[BYTE_W];
					if (!word_s1[BYTE_W]) step_index_q[ch_s1] <= word_s1[INDEX_W-1:0];
				end
				OP_DATA: begin
					if (!index_invalid_q[ch_s1]) begin
						predictor_q[ch_s1]  <= lin_sat;
						step_index_q[ch_s1] <= idx_clamped;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register
	logic emit;
	assign emit = s1_go && op_s1 != OP_INDEX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pcm.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			channel_q <= ch_s1;
			if (op_s1 == OP_SAMPLE) begin
				sample_q <= $signed(word_s1);
				last_q   <= 1'b1;
			end else begin
				sample_q <= index_invalid_q[ch_s1] ? '0 : lin_sat;
				last_q   <= phase_s1;
			end
		end
	end

	assign pcm.valid   = out_valid_q;
	assign pcm.sample  = sample_q;
	assign pcm.channel = channel_q;
	assign pcm.last    = last_q;

	// Checks
	a_phase_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && phase_s1) |-> $past(valid_s1 && op_s1 == OP_DATA))
		else $error("second nibble without a first");

	a_busy_on_first_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && op_s1 == OP_DATA && !phase_s1) |-> !adpcm.ready)
		else $error("byte accepted while first nibble pending");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_index_q[0] <= INDEX_MAX) && (step_index_q[1] <= INDEX_MAX))
		else $error("step index out of range");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && op_s1 != OP_INDEX))
		else $error("result without a decoded item");

endmodule

`default_nettype wire
